@@ design/wrmm_pkg.sv @@
package wrmm_pkg;

  localparam int CHANNELS   = 16;
  localparam int WINDOW_MAX = 1024;

  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_IN_W    = 4;
  localparam int SAMPLE_W   = 16;
  localparam int LEVEL_W    = 16;
  localparam int LEN_W      = 11;
  localparam int RECIP_W    = 16;
  localparam int MASK_W     = 16;
  localparam int SUM_W      = 48;
  localparam int SQ_W       = 32;
  localparam int PROD_W     = SUM_W + RECIP_W;
  localparam int TICK_W     = $clog2(WINDOW_MAX + 1);
  localparam int LEN_CMP_W  = (LEN_W > TICK_W) ? LEN_W : TICK_W;
  localparam int ROOT_STEPS = SUM_W / 2;
  localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH = 2'd0,
    CFG_WINDOW_RECIP  = 2'd1,
    CFG_MEAN_MASK     = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [LEN_W-1:0]   window_length;
    logic [RECIP_W-1:0] window_reciprocal;
    logic [MASK_W-1:0]  mean_mode_mask;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic square;
    logic accumulate;
    logic rd;
    logic mul;
    logic root_init;
    logic root_step;
    logic emit;
    logic clr_tick;
  } dp_cmd_t;

  typedef struct packed {
    logic win_end;
    logic mean_sel;
    logic root_last;
    logic last_ch;
  } dp_status_t;

endpackage

@@ design/wrmm_cfg.sv @@
module wrmm_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wrmm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wrmm_pkg::CFG_DATA_W-1:0]   cfg_data,
  output wrmm_pkg::cfg_t                    cfg
);
  import wrmm_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_length     <= LEN_W'(160);
      cfg.window_reciprocal <= RECIP_W'(410);
      cfg.mean_mode_mask    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WINDOW_LENGTH: cfg.window_length     <= cfg_data[LEN_W-1:0];
        CFG_WINDOW_RECIP:  cfg.window_reciprocal <= cfg_data[RECIP_W-1:0];
        CFG_MEAN_MASK:     cfg.mean_mode_mask    <= cfg_data[MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ design/wrmm_ctrl.sv @@
module wrmm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  wrmm_pkg::dp_status_t  status,
  output wrmm_pkg::dp_cmd_t     cmd
);
  import wrmm_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SQR   = 8'b0000_0010,
    S_ADD   = 8'b0000_0100,
    S_RD    = 8'b0000_1000,
    S_MUL   = 8'b0001_0000,
    S_RINIT = 8'b0010_0000,
    S_ROOT  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_SQR;
        end
      end
      S_SQR: begin
        cmd.square = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.accumulate = 1'b1;
        state_next     = status.win_end ? S_RD : S_IDLE;
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = status.mean_sel ? S_OUT : S_RINIT;
      end
      S_RINIT: begin
        cmd.root_init = 1'b1;
        state_next    = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (status.root_last) state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.emit = 1'b1;
          if (status.last_ch) begin
            cmd.clr_tick = 1'b1;
            state_next   = S_IDLE;
          end else begin
            state_next = S_RD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.emit) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ design/wrmm_dp.sv @@
module wrmm_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  wrmm_pkg::cfg_t                      cfg,
  input  wrmm_pkg::dp_cmd_t                   cmd,
  output wrmm_pkg::dp_status_t                status,
  input  logic [wrmm_pkg::CH_IN_W-1:0]        channel,
  input  logic signed [wrmm_pkg::SAMPLE_W-1:0] sample,
  input  logic                                tick_end,
  output logic [wrmm_pkg::CH_IN_W-1:0]        result_channel,
  output logic signed [wrmm_pkg::LEVEL_W-1:0] level,
  output logic                                last_channel
);
  import wrmm_pkg::*;

  localparam logic [CH_IN_W:0]       CHANNELS_EXT = (CH_IN_W+1)'(CHANNELS);
  localparam logic [LEN_CMP_W-1:0]   WMAX_EXT     = LEN_CMP_W'(WINDOW_MAX);
  localparam logic [SUM_W-1:0]       LEVEL_MAX    = SUM_W'(32767);
  localparam logic [SUM_W-1:0]       LEVEL_NEG    = SUM_W'(32768);
  localparam logic [PROD_W-1:0]      ROUND_HALF   = PROD_W'(32768);

  logic [CH_IN_W-1:0]          in_ch;
  logic signed [SAMPLE_W-1:0]  in_sample;
  logic                        in_tend;
  logic [SQ_W-1:0]             sq;
  logic signed [SUM_W-1:0]     sums [CHANNELS];
  logic [TICK_W-1:0]           tick;
  logic [CH_W-1:0]             idx;
  logic [SUM_W-1:0]            mag;
  logic                        neg;
  logic                        mean_sel;
  logic [PROD_W-1:0]           prod;
  logic [SUM_W-1:0]            rem;
  logic [SUM_W-1:0]            root;
  logic [SUM_W-1:0]            bitv;
  logic [ROOT_CNT_W-1:0]       root_cnt;

  logic                        ch_ok;
  logic [CH_W-1:0]             in_idx;
  logic signed [SUM_W:0]       addend;
  logic signed [SUM_W:0]       acc;
  logic signed [SUM_W-1:0]     acc_sat;
  logic [LEN_CMP_W-1:0]        wl_ext;
  logic [TICK_W-1:0]           len_eff;
  logic [TICK_W-1:0]           tick_next;
  logic signed [SUM_W-1:0]     rd_sum;
  logic [SUM_W-1:0]            trial;
  logic [PROD_W-1:0]           rounded;
  logic [SUM_W-1:0]            mean_v;
  logic [SUM_W-1:0]            root_r;
  logic [LEVEL_W-1:0]          level_next;

  assign ch_ok  = {1'b0, in_ch} < CHANNELS_EXT;
  assign in_idx = in_ch[CH_W-1:0];

  always_comb begin
    if (cfg.mean_mode_mask[in_ch]) addend = (SUM_W+1)'(in_sample);
    else addend = {{(SUM_W+1-SQ_W){1'b0}}, sq};
    acc = {sums[in_idx][SUM_W-1], sums[in_idx]} + addend;
    if (acc[SUM_W] != acc[SUM_W-1]) acc_sat = {acc[SUM_W], {(SUM_W-1){~acc[SUM_W]}}};
    else acc_sat = acc[SUM_W-1:0];
  end

  always_comb begin
    wl_ext = LEN_CMP_W'(cfg.window_length);
    if (wl_ext == '0) len_eff = TICK_W'(1);
    else if (wl_ext > WMAX_EXT) len_eff = TICK_W'(WINDOW_MAX);
    else len_eff = TICK_W'(wl_ext);
    tick_next = tick + TICK_W'(1);
  end

  assign rd_sum = sums[idx];
  assign trial  = root + bitv;

  always_comb begin
    rounded = prod + ROUND_HALF;
    mean_v  = rounded[PROD_W-1:RECIP_W];
    root_r  = root + SUM_W'(rem > root);
    if (mean_sel) begin
      if (neg) begin
        if (mean_v > LEVEL_NEG) level_next = LEVEL_W'(16'h8000);
        else level_next = LEVEL_W'(SUM_W'(0) - mean_v);
      end else begin
        if (mean_v > LEVEL_MAX) level_next = LEVEL_W'(16'h7FFF);
        else level_next = mean_v[LEVEL_W-1:0];
      end
    end else begin
      if (root_r > LEVEL_MAX) level_next = LEVEL_W'(16'h7FFF);
      else level_next = root_r[LEVEL_W-1:0];
    end
  end

  assign status.win_end   = in_tend && (tick_next >= len_eff);
  assign status.mean_sel  = mean_sel;
  assign status.root_last = root_cnt == '0;
  assign status.last_ch   = idx == CH_W'(CHANNELS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) sums[i] <= '0;
      tick <= '0;
      idx  <= '0;
    end else begin
      if (cmd.accumulate) begin
        if (ch_ok) sums[in_idx] <= acc_sat;
        if (in_tend && !status.win_end) tick <= tick_next;
        idx <= '0;
      end
      if (cmd.emit) begin
        sums[idx] <= '0;
        idx       <= idx + CH_W'(1);
      end
      if (cmd.clr_tick) tick <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_ch     <= channel;
      in_sample <= sample;
      in_tend   <= tick_end;
    end
    if (cmd.square) sq <= SQ_W'(in_sample * in_sample);
    if (cmd.rd) begin
      mean_sel <= cfg.mean_mode_mask[idx];
      neg      <= rd_sum[SUM_W-1];
      if (cfg.mean_mode_mask[idx])
        mag <= rd_sum[SUM_W-1] ? SUM_W'(0) - SUM_W'(rd_sum) : SUM_W'(rd_sum);
      else
        mag <= rd_sum[SUM_W-1] ? '0 : SUM_W'(rd_sum);
    end
    if (cmd.mul) prod <= PROD_W'(mag) * PROD_W'(cfg.window_reciprocal);
    if (cmd.root_init) begin
      rem      <= prod[PROD_W-1:RECIP_W];
      root     <= '0;
      bitv     <= SUM_W'(1) << (SUM_W - 2);
      root_cnt <= ROOT_CNT_W'(ROOT_STEPS - 1);
    end
    if (cmd.root_step) begin
      if (rem >= trial) begin
        rem  <= rem - trial;
        root <= (root >> 1) + bitv;
      end else begin
        root <= root >> 1;
      end
      bitv     <= bitv >> 2;
      root_cnt <= root_cnt - ROOT_CNT_W'(1);
    end
    if (cmd.emit) begin
      result_channel <= CH_IN_W'(idx);
      level          <= level_next;
      last_channel   <= status.last_ch;
    end
  end

endmodule

@@ design/windowed_rms_mean_meter.sv @@
// Multichannel windowed RMS / mean meter.
// Input channel (in_valid/in_ready): one beat carries channel, sample (Q1.15)
// and tick_end. The block takes one beat, then squares and accumulates it
// before it can take the next beat.
// A beat with tick_end set closes a sampling tick; when the tick count
// reaches window_length, the block reports one beat per channel on the
// output channel (out_valid/out_ready), channel 0 first, last_channel set
// on the final one, clearing each sum as its result leaves.
// Per channel the report does one read and one 48x16 multiply; in RMS mode
// a root init step and a square-root unit that retires two bits of the
// 48-bit mean square per cycle follow. No input is taken until the report
// of a window is done.
// The result register holds one beat; while the receiver stalls, the report
// waits and the input channel stays closed until the report finishes.
// Configuration (cfg_valid/cfg_ready) is always ready; write only while idle.
// Synchronous reset restores window_length 160, reciprocal 410, RMS mode on
// all channels, and clears sums, tick count and out_valid.
module windowed_rms_mean_meter (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [wrmm_pkg::CH_IN_W-1:0]         channel,
  input  logic signed [wrmm_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 tick_end,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [wrmm_pkg::CH_IN_W-1:0]         result_channel,
  output logic signed [wrmm_pkg::LEVEL_W-1:0]  level,
  output logic                                 last_channel,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wrmm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wrmm_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import wrmm_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  wrmm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wrmm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  wrmm_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .status         (status),
    .channel        (channel),
    .sample         (sample),
    .tick_end       (tick_end),
    .result_channel (result_channel),
    .level          (level),
    .last_channel   (last_channel)
  );

endmodule

@@ design/wrmm_checker.sv @@
module wrmm_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [wrmm_pkg::CH_IN_W-1:0]         result_channel,
  input logic signed [wrmm_pkg::LEVEL_W-1:0]  level,
  input logic                                 last_channel
);
  import wrmm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(level)
      && $stable(result_channel) && $stable(last_channel))
    else $error("result beat changed while stalled");

  a_in_gap: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on back-to-back cycles");

  a_last_ch: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_channel |-> result_channel == CH_IN_W'(CHANNELS - 1))
    else $error("last_channel on wrong channel");

  a_first_after_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_channel |=> !out_valid || result_channel == '0)
    else $error("report did not restart at channel 0");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind windowed_rms_mean_meter wrmm_checker u_wrmm_checker (.*);
